// File: rtl/wss_pkg.sv
// Shared types, codes and helper functions of the water sampling sequencer.
`default_nettype none

package wss_pkg;

    // Event codes carried on the op field.
    localparam logic [2:0] OpTick   = 3'd0;
    localparam logic [2:0] OpStart  = 3'd1;
    localparam logic [2:0] OpNear   = 3'd2;
    localparam logic [2:0] OpStatus = 3'd3;
    localparam logic [2:0] OpAbort  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CfgMaxBottles = 2'd0;
    localparam logic [1:0] CfgTimeout    = 2'd1;

    localparam logic [7:0] MaxBottlesReset = 8'd12;
    localparam logic [7:0] TimeoutReset    = 8'd10;

    // Resends allowed before the sequencer gives up.
    localparam logic [2:0] MaxTries = 3'd5;

    // Command codes.
    localparam logic [1:0] CmdNone   = 2'd0;
    localparam logic [1:0] CmdClean  = 2'd1;
    localparam logic [1:0] CmdSample = 2'd2;

    // Bottle log codes.
    localparam logic [1:0] LogNone   = 2'd0;
    localparam logic [1:0] LogOk     = 2'd1;
    localparam logic [1:0] LogFailed = 2'd2;

    // Sample type codes.
    localparam logic [1:0] TypeNone = 2'd0;
    localparam logic [1:0] TypeDisc = 2'd1;
    localparam logic [1:0] TypePump = 2'd2;

    // Firmware report codes.
    localparam logic [3:0] FwCleanDisc    = 4'd2;
    localparam logic [3:0] FwCleanPump    = 4'd3;
    localparam logic [3:0] FwCleanDone    = 4'd8;
    localparam logic [3:0] FwSampleDone   = 4'd1;
    localparam logic [3:0] FwSampleFailed = 4'd2;
    localparam logic [3:0] FwSampleDisc   = 4'd5;
    localparam logic [3:0] FwSamplePump   = 4'd6;

    // Phase codes as seen on the phase output.
    localparam logic [3:0] PhCodeStop        = 4'd0;
    localparam logic [3:0] PhCodeMoving      = 4'd1;
    localparam logic [3:0] PhCodeClean       = 4'd2;
    localparam logic [3:0] PhCodeCleaning    = 4'd3;
    localparam logic [3:0] PhCodeCleanDone   = 4'd4;
    localparam logic [3:0] PhCodeSample      = 4'd5;
    localparam logic [3:0] PhCodeSampling    = 4'd6;
    localparam logic [3:0] PhCodeSampleDone  = 4'd7;
    localparam logic [3:0] PhCodeSampleFail  = 4'd8;
    localparam logic [3:0] PhCodeManeuverEnd = 4'd9;
    localparam logic [3:0] PhCodeFull        = 4'd10;

    // Sequencer phase, one-hot.
    typedef enum logic [10:0] {
        PH_STOP         = 11'b000_0000_0001,
        PH_MOVING       = 11'b000_0000_0010,
        PH_CLEAN        = 11'b000_0000_0100,
        PH_CLEANING     = 11'b000_0000_1000,
        PH_CLEAN_DONE   = 11'b000_0001_0000,
        PH_SAMPLE       = 11'b000_0010_0000,
        PH_SAMPLING     = 11'b000_0100_0000,
        PH_SAMPLE_DONE  = 11'b000_1000_0000,
        PH_SAMPLE_FAIL  = 11'b001_0000_0000,
        PH_MANEUVER_END = 11'b010_0000_0000,
        PH_FULL         = 11'b100_0000_0000
    } phase_t;

    function automatic logic [3:0] phase_code(input phase_t p);
        logic [3:0] c;
        begin
            case (p)
                PH_STOP:         c = PhCodeStop;
                PH_MOVING:       c = PhCodeMoving;
                PH_CLEAN:        c = PhCodeClean;
                PH_CLEANING:     c = PhCodeCleaning;
                PH_CLEAN_DONE:   c = PhCodeCleanDone;
                PH_SAMPLE:       c = PhCodeSample;
                PH_SAMPLING:     c = PhCodeSampling;
                PH_SAMPLE_DONE:  c = PhCodeSampleDone;
                PH_SAMPLE_FAIL:  c = PhCodeSampleFail;
                PH_MANEUVER_END: c = PhCodeManeuverEnd;
                PH_FULL:         c = PhCodeFull;
                default:         c = PhCodeStop;
            endcase
            return c;
        end
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        begin
            return (v == 8'hFF) ? 8'hFF : v + 8'd1;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/water_sampling_sequencer_unit.sv
// Top level of the water sampling sequencer: event register, phase logic, result register.
`default_nettype none

// Channel  | Direction | Handshake           | Beat contents
// ---------+-----------+---------------------+---------------------------------------------
// in       | inbound   | in_valid/in_ready   | op, bottles_to_sample, sample_type,
//          |           |                     | fw_clean_state, fw_sample_state
// out      | outbound  | out_valid/out_ready | command, sample_argument, log_kind,
//          |           |                     | bottle_number, maneuver_done, phase
// cfg      | inbound   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Every event beat produces exactly one result beat. The phase logic settles
// each beat from the event register into the result register, so one beat can be
// taken every cycle unless the output stalls. The sequencer state is updated in
// the same cycle the result is loaded, which keeps back-to-back events
// consistent. Reset (rst_n low) clears the valid flags and sequencer state and
// puts the configuration registers at their defaults. When the result register
// is held by out_ready low, the event register holds too and in_ready drops only
// once both are full. Configuration writes are always taken.

module water_sampling_sequencer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] op,
    input  wire logic [3:0] bottles_to_sample,
    input  wire logic [1:0] sample_type,
    input  wire logic [3:0] fw_clean_state,
    input  wire logic [3:0] fw_sample_state,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      command,
    output logic            sample_argument,
    output logic [1:0]      log_kind,
    output logic [7:0]      bottle_number,
    output logic            maneuver_done,
    output logic [3:0]      phase,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    // Configuration registers.
    logic [7:0] max_bottles_reg;
    logic [7:0] timeout_reg;

    // Event register.
    logic       ev_valid_reg;
    logic [2:0] ev_op_reg;
    logic [3:0] ev_bottles_reg;
    logic [1:0] ev_type_reg;
    logic [3:0] ev_clean_reg;
    logic [3:0] ev_sample_reg;

    // Sequencer state.
    wss_pkg::phase_t phase_reg, phase_next;
    logic [2:0] tries_reg, tries_next;
    logic [7:0] wait_reg, wait_next;
    logic [7:0] spot_reg, spot_next;
    logic [7:0] total_reg, total_next;
    logic [3:0] target_reg, target_next;
    logic [1:0] type_reg, type_next;
    logic       start_pend_reg, start_pend_next;
    logic       near_pend_reg, near_pend_next;
    logic       full_reg, full_next;
    logic       abort_reg, abort_next;
    logic [3:0] clean_rep_reg, clean_rep_next;
    logic [3:0] sample_rep_reg, sample_rep_next;

    // Result register.
    logic       out_valid_reg;
    logic [1:0] cmd_reg, cmd_next;
    logic       arg_reg, arg_next;
    logic [1:0] log_reg, log_next;
    logic [7:0] bottle_reg, bottle_next;
    logic       done_reg, done_next;
    logic [3:0] phase_out_reg, phase_out_next;

    logic advance;
    logic fire;

    // The result register is free when empty or being drained this cycle.
    assign advance   = !out_valid_reg || out_ready;
    assign fire      = ev_valid_reg && advance;
    assign in_ready  = !ev_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bottles_reg <= wss_pkg::MaxBottlesReset;
            timeout_reg     <= wss_pkg::TimeoutReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wss_pkg::CfgMaxBottles: max_bottles_reg <= cfg_data;
                wss_pkg::CfgTimeout:    timeout_reg     <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Event register: loads on every accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ev_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ev_op_reg      <= op;
            ev_bottles_reg <= bottles_to_sample;
            ev_type_reg    <= sample_type;
            ev_clean_reg   <= fw_clean_state;
            ev_sample_reg  <= fw_sample_state;
        end
    end

    // Phase logic: apply the event, then evaluate the phase once.
    always_comb
    begin
        logic is_clean;
        logic answered;
        logic overdue;

        phase_next      = phase_reg;
        tries_next      = tries_reg;
        wait_next       = wait_reg;
        spot_next       = spot_reg;
        total_next      = total_reg;
        target_next     = target_reg;
        type_next       = type_reg;
        start_pend_next = start_pend_reg;
        near_pend_next  = near_pend_reg;
        full_next       = full_reg;
        abort_next      = abort_reg;
        clean_rep_next  = clean_rep_reg;
        sample_rep_next = sample_rep_reg;
        cmd_next        = wss_pkg::CmdNone;
        log_next        = wss_pkg::LogNone;
        done_next       = 1'b0;

        case (ev_op_reg)
            wss_pkg::OpTick:
            begin
                wait_next = wss_pkg::sat_inc(wait_reg);
            end
            wss_pkg::OpStart:
            begin
                target_next = ev_bottles_reg;
                type_next   = ev_type_reg;
                if (phase_reg == wss_pkg::PH_STOP)
                    start_pend_next = 1'b1;
            end
            wss_pkg::OpNear:
            begin
                near_pend_next = 1'b1;
            end
            wss_pkg::OpStatus:
            begin
                clean_rep_next  = ev_clean_reg;
                sample_rep_next = ev_sample_reg;
            end
            wss_pkg::OpAbort:
            begin
                if (phase_reg != wss_pkg::PH_STOP && !abort_reg)
                begin
                    abort_next = 1'b1;
                    phase_next = wss_pkg::PH_STOP;
                end
            end
            default: ;
        endcase

        // A command is overdue once the tick count reaches the timeout.
        overdue  = (wait_next >= timeout_reg);
        is_clean = (phase_next == wss_pkg::PH_CLEAN);
        answered = is_clean
            ? (clean_rep_next == wss_pkg::FwCleanDisc || clean_rep_next == wss_pkg::FwCleanPump)
            : (sample_rep_next == wss_pkg::FwSampleDisc
               || sample_rep_next == wss_pkg::FwSamplePump);

        case (phase_next)
            wss_pkg::PH_STOP:
            begin
                if (start_pend_next)
                begin
                    phase_next      = wss_pkg::PH_MOVING;
                    start_pend_next = 1'b0;
                    abort_next      = 1'b0;
                    spot_next       = 8'd0;
                end
            end
            wss_pkg::PH_MOVING:
            begin
                if (near_pend_next)
                begin
                    if (target_next != 4'd0
                        && (type_next == wss_pkg::TypeDisc || type_next == wss_pkg::TypePump)
                        && !full_next)
                    begin
                        cmd_next   = wss_pkg::CmdClean;
                        wait_next  = 8'd0;
                        phase_next = wss_pkg::PH_CLEAN;
                    end
                    else
                    begin
                        phase_next = wss_pkg::PH_MANEUVER_END;
                    end
                    near_pend_next = 1'b0;
                end
            end
            wss_pkg::PH_CLEAN, wss_pkg::PH_SAMPLE:
            begin
                if (answered)
                begin
                    phase_next = is_clean ? wss_pkg::PH_CLEANING : wss_pkg::PH_SAMPLING;
                    tries_next = 3'd0;
                end
                else if (overdue)
                begin
                    if (tries_next < wss_pkg::MaxTries)
                    begin
                        cmd_next   = is_clean ? wss_pkg::CmdClean : wss_pkg::CmdSample;
                        tries_next = tries_next + 3'd1;
                        wait_next  = 8'd0;
                    end
                    else
                    begin
                        // Out of resends: give up silently.
                        tries_next = 3'd0;
                        phase_next = wss_pkg::PH_STOP;
                    end
                end
            end
            wss_pkg::PH_CLEANING:
            begin
                if (clean_rep_next == wss_pkg::FwCleanDone)
                    phase_next = wss_pkg::PH_CLEAN_DONE;
            end
            wss_pkg::PH_CLEAN_DONE:
            begin
                cmd_next   = wss_pkg::CmdSample;
                wait_next  = 8'd0;
                phase_next = wss_pkg::PH_SAMPLE;
            end
            wss_pkg::PH_SAMPLING:
            begin
                if (sample_rep_next == wss_pkg::FwSampleDone)
                begin
                    phase_next = wss_pkg::PH_SAMPLE_DONE;
                    spot_next  = wss_pkg::sat_inc(spot_next);
                    total_next = wss_pkg::sat_inc(total_next);
                end
                else if (sample_rep_next == wss_pkg::FwSampleFailed)
                begin
                    phase_next = wss_pkg::PH_SAMPLE_FAIL;
                    total_next = wss_pkg::sat_inc(total_next);
                end
            end
            wss_pkg::PH_SAMPLE_DONE:
            begin
                log_next = wss_pkg::LogOk;
                // Being full wins over asking for another bottle.
                if (total_next >= max_bottles_reg)
                    phase_next = wss_pkg::PH_FULL;
                else if (spot_next < {4'd0, target_next})
                    phase_next = wss_pkg::PH_SAMPLE;
                else
                    phase_next = wss_pkg::PH_MANEUVER_END;
            end
            wss_pkg::PH_SAMPLE_FAIL:
            begin
                log_next   = wss_pkg::LogFailed;
                phase_next = (total_next >= max_bottles_reg) ? wss_pkg::PH_FULL
                                                             : wss_pkg::PH_SAMPLE;
            end
            wss_pkg::PH_MANEUVER_END:
            begin
                start_pend_next = 1'b0;
                done_next       = 1'b1;
                phase_next      = wss_pkg::PH_STOP;
            end
            wss_pkg::PH_FULL:
            begin
                done_next  = 1'b1;
                phase_next = wss_pkg::PH_STOP;
                full_next  = 1'b1;
            end
            default:
            begin
                phase_next = wss_pkg::PH_STOP;
            end
        endcase

        arg_next       = (cmd_next == wss_pkg::CmdSample) && (type_next == wss_pkg::TypePump);
        bottle_next    = (log_next != wss_pkg::LogNone) ? total_next : 8'd0;
        phase_out_next = wss_pkg::phase_code(phase_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= wss_pkg::PH_STOP;
            tries_reg      <= 3'd0;
            wait_reg       <= 8'd0;
            spot_reg       <= 8'd0;
            total_reg      <= 8'd0;
            target_reg     <= 4'd0;
            type_reg       <= wss_pkg::TypeNone;
            start_pend_reg <= 1'b0;
            near_pend_reg  <= 1'b0;
            full_reg       <= 1'b0;
            abort_reg      <= 1'b0;
            clean_rep_reg  <= 4'd0;
            sample_rep_reg <= 4'd0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            tries_reg      <= tries_next;
            wait_reg       <= wait_next;
            spot_reg       <= spot_next;
            total_reg      <= total_next;
            target_reg     <= target_next;
            type_reg       <= type_next;
            start_pend_reg <= start_pend_next;
            near_pend_reg  <= near_pend_next;
            full_reg       <= full_next;
            abort_reg      <= abort_next;
            clean_rep_reg  <= clean_rep_next;
            sample_rep_reg <= sample_rep_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= ev_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cmd_reg       <= cmd_next;
            arg_reg       <= arg_next;
            log_reg       <= log_next;
            bottle_reg    <= bottle_next;
            done_reg      <= done_next;
            phase_out_reg <= phase_out_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign command         = cmd_reg;
    assign sample_argument = arg_reg;
    assign log_kind        = log_reg;
    assign bottle_number   = bottle_reg;
    assign maneuver_done   = done_reg;
    assign phase           = phase_out_reg;

endmodule

`default_nettype wire

// File: rtl/wss_checker.sv
// Port-level checker of the water sampling sequencer and its bind statement.
`default_nettype none

module wss_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] command,
    input wire logic       sample_argument,
    input wire logic [1:0] log_kind,
    input wire logic [7:0] bottle_number,
    input wire logic       maneuver_done,
    input wire logic [3:0] phase
);

    // A stalled result beat stays and keeps its phase and command.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(command))
        else $error("result beat dropped or changed while stalled");

    // The pump argument only rides on a sample command.
    a_arg_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_argument |-> command == wss_pkg::CmdSample)
        else $error("sample argument without sample command");

    // A bottle number is only reported with a log event.
    a_bottle_log: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && log_kind == wss_pkg::LogNone |-> bottle_number == 8'd0)
        else $error("bottle number without log event");

    // A finished maneuver always leaves the sequencer stopped.
    a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && maneuver_done |-> phase == wss_pkg::PhCodeStop
                                       && command == wss_pkg::CmdNone)
        else $error("maneuver done without stop");

    // A clean command is only sent from the clean request phase.
    a_clean_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command == wss_pkg::CmdClean |-> phase == wss_pkg::PhCodeClean)
        else $error("clean command outside clean request");

endmodule

bind water_sampling_sequencer_unit wss_checker u_wss_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .command         (command),
    .sample_argument (sample_argument),
    .log_kind        (log_kind),
    .bottle_number   (bottle_number),
    .maneuver_done   (maneuver_done),
    .phase           (phase)
);

`default_nettype wire

// File: tb/tb_water_sampling_sequencer_unit.sv
// Self-checking testbench of the water sampling sequencer: directed table, then random sequences.
module tb_water_sampling_sequencer_unit;

    // Op value with no event behind it, and the sample type that counts as none.
    localparam logic [2:0] OpUnused  = 3'd7;
    localparam logic [1:0] TypeThree = 2'd3;

    // Cycles with no beat on any channel before the run is declared hung. The
    // longest honest wait is a sender or receiver stall streak at 62 percent per
    // cycle, and this limit is many times the longest such streak to expect.
    localparam int StallLimit = 1000;

    // Cycles allowed after the last result for anything late to show up.
    localparam int SettleCycles = 8;

    // One input beat, as carried on the five payload ports.
    typedef struct packed {
        logic [2:0] op;
        logic [3:0] bottles;
        logic [1:0] stype;
        logic [3:0] fw_clean;
        logic [3:0] fw_sample;
    } event_t;

    // One output beat, as carried on the six result ports.
    typedef struct packed {
        logic [1:0] cmd;
        logic       arg;
        logic [1:0] lg;
        logic [7:0] bottle;
        logic       done;
        logic [3:0] ph;
    } result_t;

    // A row of the directed table. When fixed is set, res is the result typed
    // in by hand and it is what the output must show; otherwise the predictor
    // decides the expected result.
    typedef struct packed {
        event_t  ev;
        logic    fixed;
        result_t res;
    } row_t;

    localparam int DirRows = 23;

    // The directed walk: reset behavior, unknown op with every field at its
    // top value, abort while stopped, one full clean and sample cycle with a
    // pump (good sample, then a failed one), abort mid run and a repeated
    // abort, a start with no bottles wanted, a start with type three, and a
    // status beat with both reports out of range.
    row_t script [DirRows] = '{
        '{'{wss_pkg::OpTick, 4'd0, wss_pkg::TypeNone, 4'd0, 4'd0}, 1'b1,
          '{wss_pkg::CmdNone, 1'b0, wss_pkg::LogNone, 8'd0, 1'b0, wss_pkg::PhCodeStop}},
        '{'{OpUnused, 4'hF, TypeThree, 4'hF, 4'hF}, 1'b1,
          '{wss_pkg::CmdNone, 1'b0, wss_pkg::LogNone, 8'd0, 1'b0, wss_pkg::PhCodeStop}},
        '{'{wss_pkg::OpAbort, 4'd0, wss_pkg::TypeNone, 4'd0, 4'd0}, 1'b1,
          '{wss_pkg::CmdNone, 1'b0, wss_pkg::LogNone, 8'd0, 1'b0, wss_pkg::PhCodeStop}},
        '{'{wss_pkg::OpStart, 4'd12, wss_pkg::TypePump, 4'd0, 4'd0}, 1'b1,
          '{wss_pkg::CmdNone, 1'b0, wss_pkg::LogNone, 8'd0, 1'b0, wss_pkg::PhCodeMoving}},
        '{'{wss_pkg::OpNear, 4'd0, wss_pkg::TypeNone, 4'd0, 4'd0}, 1'b1,
          '{wss_pkg::CmdClean, 1'b0, wss_pkg::LogNone, 8'd0, 1'b0, wss_pkg::PhCodeClean}},
        '{'{wss_pkg::OpStatus, 4'd0, wss_pkg::TypeNone, wss_pkg::FwCleanPump, 4'd0},
          1'b0, '0},
        '{'{wss_pkg::OpStatus, 4'd0, wss_pkg::TypeNone, wss_pkg::FwCleanDone, 4'd0},
          1'b0, '0},
        '{'{wss_pkg::OpTick, 4'd0, wss_pkg::TypeNone, 4'd0, 4'd0}, 1'b1,
          '{wss_pkg::CmdSample, 1'b1, wss_pkg::LogNone, 8'd0, 1'b0, wss_pkg::PhCodeSample}},
        '{'{wss_pkg::OpStatus, 4'd0, wss_pkg::TypeNone, 4'd0, wss_pkg::FwSamplePump},
          1'b0, '0},
        '{'{wss_pkg::OpStatus, 4'd0, wss_pkg::TypeNone, 4'd0, wss_pkg::FwSampleDone},
          1'b0, '0},
        '{'{wss_pkg::OpTick, 4'd0, wss_pkg::TypeNone, 4'd0, 4'd0}, 1'b0, '0},
        '{'{wss_pkg::OpStatus, 4'd0, wss_pkg::TypeNone, 4'd0, wss_pkg::FwSampleDisc},
          1'b0, '0},
        '{'{wss_pkg::OpStatus, 4'd0, wss_pkg::TypeNone, 4'd0, wss_pkg::FwSampleFailed},
          1'b0, '0},
        '{'{wss_pkg::OpTick, 4'd0, wss_pkg::TypeNone, 4'd0, 4'd0}, 1'b0, '0},
        '{'{wss_pkg::OpAbort, 4'd0, wss_pkg::TypeNone, 4'd0, 4'd0}, 1'b0, '0},
        '{'{wss_pkg::OpAbort, 4'd0, wss_pkg::TypeNone, 4'd0, 4'd0}, 1'b1,
          '{wss_pkg::CmdNone, 1'b0, wss_pkg::LogNone, 8'd0, 1'b0, wss_pkg::PhCodeStop}},
        '{'{wss_pkg::OpStart, 4'd0, wss_pkg::TypeDisc, 4'd0, 4'd0}, 1'b0, '0},
        '{'{wss_pkg::OpNear, 4'd0, wss_pkg::TypeNone, 4'd0, 4'd0}, 1'b0, '0},
        '{'{wss_pkg::OpTick, 4'd0, wss_pkg::TypeNone, 4'd0, 4'd0}, 1'b0, '0},
        '{'{wss_pkg::OpStart, 4'hF, TypeThree, 4'd0, 4'd0}, 1'b0, '0},
        '{'{wss_pkg::OpNear, 4'd0, wss_pkg::TypeNone, 4'd0, 4'd0}, 1'b0, '0},
        '{'{wss_pkg::OpTick, 4'd0, wss_pkg::TypeNone, 4'd0, 4'd0}, 1'b0, '0},
        '{'{wss_pkg::OpStatus, 4'd0, wss_pkg::TypeNone, 4'hF, 4'hF}, 1'b1,
          '{wss_pkg::CmdNone, 1'b0, wss_pkg::LogNone, 8'd0, 1'b0, wss_pkg::PhCodeStop}}
    };

    // Settings walked by the random part. Bottle capacity stays out of reach
    // until the last setting, because a full sampler never samples again and
    // would starve everything after it. Timeouts go through zero (always
    // overdue), one, a middling value and the top value.
    localparam int NumSettings = 5;
    int capacity_plan [NumSettings] = '{255, 255, 200, 255, 0};
    int timeout_plan  [NumSettings] = '{3, 0, 255, 1, 10};
    int beats_plan    [NumSettings] = '{400, 300, 300, 400, 400};
    int send_idle_plan [NumSettings] = '{15, 15, 62, 62, 0};
    int recv_idle_plan [NumSettings] = '{62, 62, 15, 15, 0};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] op = wss_pkg::OpTick;
    logic [3:0] bottles_to_sample = 4'd0;
    logic [1:0] sample_type = wss_pkg::TypeNone;
    logic [3:0] fw_clean_state = 4'd0;
    logic [3:0] fw_sample_state = 4'd0;

    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] command;
    logic       sample_argument;
    logic [1:0] log_kind;
    logic [7:0] bottle_number;
    logic       maneuver_done;
    logic [3:0] phase;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = wss_pkg::CfgMaxBottles;
    logic [7:0] cfg_data = 8'd0;

    // Predictor copy of the sequencer state and configuration, at reset values.
    logic [3:0] seq_phase = wss_pkg::PhCodeStop;
    logic [2:0] resend_count = 3'd0;
    logic [7:0] tick_count = 8'd0;
    logic [7:0] spot_count = 8'd0;
    logic [7:0] bottle_total = 8'd0;
    logic [3:0] wanted = 4'd0;
    logic [1:0] kind = wss_pkg::TypeNone;
    logic       start_req = 1'b0;
    logic       near_req = 1'b0;
    logic       sampler_full = 1'b0;
    logic       aborted = 1'b0;
    logic [3:0] clean_rep = 4'd0;
    logic [3:0] sample_rep = 4'd0;
    logic [7:0] capacity = wss_pkg::MaxBottlesReset;
    logic [7:0] answer_limit = wss_pkg::TimeoutReset;

    result_t pending_results [$];

    int send_idle_pct = 15;
    int recv_idle_pct = 62;
    int mismatches = 0;
    int events_sent = 0;
    int results_seen = 0;
    int logs_seen = 0;
    int ends_seen = 0;
    int stall_cycles = 0;

    water_sampling_sequencer_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .bottles_to_sample(bottles_to_sample),
        .sample_type      (sample_type),
        .fw_clean_state   (fw_clean_state),
        .fw_sample_state  (fw_sample_state),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .command          (command),
        .sample_argument  (sample_argument),
        .log_kind         (log_kind),
        .bottle_number    (bottle_number),
        .maneuver_done    (maneuver_done),
        .phase            (phase),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #4 clk = ~clk;

    // Applies one event to the predictor state and runs one phase evaluation,
    // returning the result beat the block must produce for it.
    function automatic result_t settle_event(input event_t e);
        result_t r;
        logic    in_clean;
        logic    answered;
        r = '0;

        // Event effects come first.
        case (e.op)
            wss_pkg::OpTick:
                if (tick_count != 8'hFF)
                    tick_count = tick_count + 8'd1;
            wss_pkg::OpStart:
            begin
                wanted = e.bottles;
                kind = e.stype;
                if (seq_phase == wss_pkg::PhCodeStop)
                    start_req = 1'b1;
            end
            wss_pkg::OpNear:
                near_req = 1'b1;
            wss_pkg::OpStatus:
            begin
                clean_rep = e.fw_clean;
                sample_rep = e.fw_sample;
            end
            wss_pkg::OpAbort:
                if (seq_phase != wss_pkg::PhCodeStop && !aborted)
                begin
                    aborted = 1'b1;
                    seq_phase = wss_pkg::PhCodeStop;
                end
            default: ;
        endcase

        in_clean = (seq_phase == wss_pkg::PhCodeClean);
        case (seq_phase)
            wss_pkg::PhCodeStop:
                if (start_req)
                begin
                    seq_phase = wss_pkg::PhCodeMoving;
                    start_req = 1'b0;
                    aborted = 1'b0;
                    spot_count = 8'd0;
                end
            wss_pkg::PhCodeMoving:
                if (near_req)
                begin
                    // Only disc and pump are real sample types; type three
                    // falls through to a plain finish like none.
                    if (wanted != 4'd0 &&
                        (kind == wss_pkg::TypeDisc || kind == wss_pkg::TypePump) &&
                        !sampler_full)
                    begin
                        r.cmd = wss_pkg::CmdClean;
                        tick_count = 8'd0;
                        seq_phase = wss_pkg::PhCodeClean;
                    end
                    else
                        seq_phase = wss_pkg::PhCodeManeuverEnd;
                    near_req = 1'b0;
                end
            wss_pkg::PhCodeClean, wss_pkg::PhCodeSample:
            begin
                answered = in_clean ?
                    (clean_rep == wss_pkg::FwCleanDisc || clean_rep == wss_pkg::FwCleanPump) :
                    (sample_rep == wss_pkg::FwSampleDisc ||
                     sample_rep == wss_pkg::FwSamplePump);
                if (answered)
                begin
                    seq_phase = in_clean ? wss_pkg::PhCodeCleaning : wss_pkg::PhCodeSampling;
                    resend_count = 3'd0;
                end
                else if (tick_count >= answer_limit)
                begin
                    // Overdue: resend, or give up silently after five resends.
                    if (resend_count < wss_pkg::MaxTries)
                    begin
                        r.cmd = in_clean ? wss_pkg::CmdClean : wss_pkg::CmdSample;
                        resend_count = resend_count + 3'd1;
                        tick_count = 8'd0;
                    end
                    else
                    begin
                        resend_count = 3'd0;
                        seq_phase = wss_pkg::PhCodeStop;
                    end
                end
            end
            wss_pkg::PhCodeCleaning:
                if (clean_rep == wss_pkg::FwCleanDone)
                    seq_phase = wss_pkg::PhCodeCleanDone;
            wss_pkg::PhCodeCleanDone:
            begin
                r.cmd = wss_pkg::CmdSample;
                tick_count = 8'd0;
                seq_phase = wss_pkg::PhCodeSample;
            end
            wss_pkg::PhCodeSampling:
                if (sample_rep == wss_pkg::FwSampleDone)
                begin
                    seq_phase = wss_pkg::PhCodeSampleDone;
                    if (spot_count != 8'hFF)
                        spot_count = spot_count + 8'd1;
                    if (bottle_total != 8'hFF)
                        bottle_total = bottle_total + 8'd1;
                end
                else if (sample_rep == wss_pkg::FwSampleFailed)
                begin
                    seq_phase = wss_pkg::PhCodeSampleFail;
                    if (bottle_total != 8'hFF)
                        bottle_total = bottle_total + 8'd1;
                end
            wss_pkg::PhCodeSampleDone:
            begin
                // The full test wins over another bottle at this spot.
                r.lg = wss_pkg::LogOk;
                if (bottle_total >= capacity)
                    seq_phase = wss_pkg::PhCodeFull;
                else if (spot_count < {4'd0, wanted})
                    seq_phase = wss_pkg::PhCodeSample;
                else
                    seq_phase = wss_pkg::PhCodeManeuverEnd;
            end
            wss_pkg::PhCodeSampleFail:
            begin
                r.lg = wss_pkg::LogFailed;
                seq_phase = (bottle_total >= capacity) ? wss_pkg::PhCodeFull
                                                       : wss_pkg::PhCodeSample;
            end
            wss_pkg::PhCodeManeuverEnd:
            begin
                start_req = 1'b0;
                r.done = 1'b1;
                seq_phase = wss_pkg::PhCodeStop;
            end
            wss_pkg::PhCodeFull:
            begin
                r.done = 1'b1;
                seq_phase = wss_pkg::PhCodeStop;
                sampler_full = 1'b1;
            end
            default:
                seq_phase = wss_pkg::PhCodeStop;
        endcase

        r.arg = (r.cmd == wss_pkg::CmdSample && kind == wss_pkg::TypePump);
        r.bottle = (r.lg != wss_pkg::LogNone) ? bottle_total : 8'd0;
        r.ph = seq_phase;
        return r;
    endfunction

    // Chooses the next random event. Most beats are what the current phase
    // needs to move on (start, arrival, the matching firmware report, ticks
    // for timeouts), with random content in the fields that do not matter;
    // the rest are raw random beats and aborts.
    function automatic event_t pick_event();
        event_t e;
        int     roll;
        e = event_t'($urandom);
        roll = $urandom_range(99);
        if (roll < 12)
            return e;
        if (roll < 15)
        begin
            e.op = wss_pkg::OpAbort;
            return e;
        end
        roll = $urandom_range(99);
        case (seq_phase)
            wss_pkg::PhCodeStop:
            begin
                e.op = (roll < 75) ? wss_pkg::OpStart : wss_pkg::OpTick;
                // Short spots mostly, so the run sees many of them.
                if ($urandom_range(9) == 0)
                    e.bottles = 4'($urandom_range(15));
                else
                    e.bottles = 4'($urandom_range(3, 1));
                if ($urandom_range(7) == 0)
                    e.stype = 2'($urandom_range(3));
                else
                    e.stype = 2'($urandom_range(2, 1));
            end
            wss_pkg::PhCodeMoving:
                e.op = (roll < 70) ? wss_pkg::OpNear : wss_pkg::OpTick;
            wss_pkg::PhCodeClean:
            begin
                e.op = (roll < 45) ? wss_pkg::OpStatus : wss_pkg::OpTick;
                e.fw_clean = $urandom_range(1) ? wss_pkg::FwCleanPump : wss_pkg::FwCleanDisc;
            end
            wss_pkg::PhCodeCleaning:
            begin
                e.op = (roll < 70) ? wss_pkg::OpStatus : wss_pkg::OpTick;
                if (roll < 55)
                    e.fw_clean = wss_pkg::FwCleanDone;
            end
            wss_pkg::PhCodeSample:
            begin
                e.op = (roll < 45) ? wss_pkg::OpStatus : wss_pkg::OpTick;
                e.fw_sample = $urandom_range(1) ? wss_pkg::FwSamplePump
                                                : wss_pkg::FwSampleDisc;
            end
            wss_pkg::PhCodeSampling:
            begin
                e.op = (roll < 75) ? wss_pkg::OpStatus : wss_pkg::OpTick;
                e.fw_sample = (roll < 55) ? wss_pkg::FwSampleDone : wss_pkg::FwSampleFailed;
            end
            default:
                e.op = wss_pkg::OpTick;
        endcase
        return e;
    endfunction

    // Drives one event beat, with a random gap in front of it, and records the
    // expected result at the edge where the beat is accepted. When no gap is
    // taken, valid simply stays high from the previous beat.
    task automatic push_event(input event_t e, input logic fixed, input result_t typed);
        result_t predicted;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        op <= e.op;
        bottles_to_sample <= e.bottles;
        sample_type <= e.stype;
        fw_clean_state <= e.fw_clean;
        fw_sample_state <= e.fw_sample;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = settle_event(e);
        pending_results.push_back(fixed ? typed : predicted);
        events_sent++;
    endtask

    // Waits until every expected result has come back, then waits out the
    // settle time so the block is surely idle.
    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Writes both configuration registers, one beat each, with valid held high
    // across the two beats.
    task automatic load_settings(input logic [7:0] cap, input logic [7:0] limit);
        cfg_valid <= 1'b1;
        cfg_index <= wss_pkg::CfgMaxBottles;
        cfg_data <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        capacity = cap;
        cfg_index <= wss_pkg::CfgTimeout;
        cfg_data <= limit;
        do
            @(posedge clk);
        while (!cfg_ready);
        answer_limit = limit;
        cfg_valid <= 1'b0;
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Result side: compare each accepted beat with the oldest expectation,
    // then decide ready for the next cycle.
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no event waiting for it");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("command", want.cmd, command);
                check_field("sample_argument", want.arg, sample_argument);
                check_field("log_kind", want.lg, log_kind);
                check_field("bottle_number", want.bottle, bottle_number);
                check_field("maneuver_done", want.done, maneuver_done);
                check_field("phase", want.ph, phase);
                results_seen++;
                if (log_kind != wss_pkg::LogNone)
                    logs_seen++;
                if (maneuver_done)
                    ends_seen++;
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Hang detector: any beat on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= StallLimit)
        begin
            $display("Timeout after %0d cycles with no beat", stall_cycles);
            $display("FAILED: results differ");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        int s;
        int n;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the configuration still at its reset values.
        for (n = 0; n < DirRows; n++)
            push_event(script[n].ev, script[n].fixed, script[n].res);

        // Random part, one block of beats per configuration setting. The idle
        // pattern shifts from a slow receiver to a slow sender and then to
        // none at all.
        for (s = 0; s < NumSettings; s++)
        begin
            in_valid <= 1'b0;
            drain_results();
            load_settings(8'(capacity_plan[s]), 8'(timeout_plan[s]));
            send_idle_pct = send_idle_plan[s];
            recv_idle_pct = recv_idle_plan[s];
            for (n = 0; n < beats_plan[s]; n++)
                push_event(pick_event(), 1'b0, '0);
        end
        in_valid <= 1'b0;
        drain_results();

        $display("Sent %0d event beats over %0d settings and checked %0d results.",
                 events_sent, NumSettings + 1, results_seen);
        $display("Saw %0d bottle log events and %0d maneuver completions.",
                 logs_seen, ends_seen);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: water_sampling_sequencer_unit.f
rtl/wss_pkg.sv
rtl/water_sampling_sequencer_unit.sv
rtl/wss_checker.sv
tb/tb_water_sampling_sequencer_unit.sv
